// ===== sv/cia_pkg.sv =====
`default_nettype none

package cia_pkg;

    localparam int ID_W     = 10;
    localparam int HANDLE_W = 32;

    // request actions
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FIND   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
    } t_cia_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     result_id;
        logic [HANDLE_W-1:0] result_handle;
    } t_cia_rsp;

endpackage

`default_nettype wire

// ===== sv/cia_ram.sv =====
`default_nettype none

// simple dual-port RAM, one write and one registered read port
module cia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/cyclic_id_allocator_unit.sv =====
// Find, remove and malformed requests: one table read in S_LOOK, then the response
//   goes to the output register once it is free; no new request until back in S_IDLE.
// Allocate: S_SCAN probes 1 .. ID_COUNT-1 entries from the cursor, one table read per
//   cycle, until a free one is found or a full lap is done; then the response is loaded.
// Reset (synchronous, active low) starts a clearing pass over the table
//   that zeroes all ID_COUNT entries; requests are stalled until it finishes.
`default_nettype none

module cyclic_id_allocator_unit
    import cia_pkg::*;
#(
    parameter int ID_COUNT = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_stall,
    input  wire t_cia_req i_req,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_stall,
    output t_cia_rsp      o_rsp
);

    // table address width; entry layout is {used, handle}
    localparam int AW    = $clog2(ID_COUNT);
    localparam int ENT_W = HANDLE_W + 1;

    // sequencer states
    localparam logic [1:0] S_CLR  = 2'd0;  // post-reset clearing sweep
    localparam logic [1:0] S_IDLE = 2'd1;  // waiting for a request
    localparam logic [1:0] S_LOOK = 2'd2;  // find / remove: one entry read
    localparam logic [1:0] S_SCAN = 2'd3;  // allocate: probe one entry a cycle

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [AW-1:0]       r_cursor, n_cursor;
    logic [AW-1:0]       r_cand, n_cand;
    logic [AW-1:0]       r_tries, n_tries;
    logic [1:0]          r_act, n_act;
    logic [ID_W-1:0]     r_id, n_id;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic                r_bad, n_bad;
    logic                r_out_valid, n_out_valid;
    t_cia_rsp            r_out, n_out;

    logic                req_fire;
    logic                out_free;
    logic                id_ok;
    logic [AW:0]         cand_inc;
    logic [AW-1:0]       cand_adv;
    logic                ent_used;
    logic [HANDLE_W-1:0] ent_handle;
    logic                scan_last;
    logic                rsp_load;
    t_cia_rsp            rsp;

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [ENT_W-1:0]    mem_wr_data;
    logic [AW-1:0]       mem_rd_addr;
    logic [ENT_W-1:0]    mem_rd_data;

    cia_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ID_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // only the sequencer fills the output register, and only when it is
    // empty or draining; a held response stalls a finishing request, and so intake
    assign o_req_stall = (r_state != S_IDLE);
    assign req_fire    = i_req_valid && !o_req_stall;
    assign out_free    = !r_out_valid || !i_rsp_stall;

    assign id_ok = (i_req.id != '0) && (32'(i_req.id) < 32'(ID_COUNT));

    // next candidate: wraps from the top of the table to ID 1, skipping 0
    assign cand_inc = {1'b0, r_cand} + (AW+1)'(1);
    assign cand_adv = (cand_inc >= (AW+1)'(ID_COUNT)) ? AW'(1) : cand_inc[AW-1:0];

    assign ent_used   = mem_rd_data[HANDLE_W];
    assign ent_handle = mem_rd_data[HANDLE_W-1:0];

    // last probe of a full lap over the ID_COUNT-1 usable IDs
    assign scan_last = (r_tries == AW'(ID_COUNT - 2));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cursor    = r_cursor;
        n_cand      = r_cand;
        n_tries     = r_tries;
        n_act       = r_act;
        n_id        = r_id;
        n_handle    = r_handle;
        n_bad       = r_bad;
        rsp_load    = 1'b0;
        rsp         = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_clr;
        mem_wr_data = '0;
        mem_rd_addr = AW'(r_id);

        unique case (r_state)
            S_CLR: begin
                mem_wr_en = 1'b1;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(ID_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // issue the first read right away so data is there next cycle
                mem_rd_addr = (i_req.action == ACT_ALLOC) ? r_cursor : AW'(i_req.id);
                if (req_fire) begin
                    n_act    = i_req.action;
                    n_id     = i_req.id;
                    n_handle = i_req.handle;
                    n_cand   = r_cursor;
                    n_tries  = '0;
                    n_bad    = !(((i_req.action == ACT_FIND) ||
                                  (i_req.action == ACT_REMOVE)) && id_ok);
                    n_state  = (i_req.action == ACT_ALLOC) ? S_SCAN : S_LOOK;
                end
            end
            S_LOOK: begin
                // re-read the same entry while the response is held back
                mem_rd_addr = AW'(r_id);
                if (out_free) begin
                    rsp_load         = 1'b1;
                    rsp.status       = ST_NOT_FOUND;
                    n_state          = S_IDLE;
                    if (!r_bad && ent_used) begin
                        rsp.status = ST_OK;
                        if (r_act == ACT_FIND) begin
                            rsp.result_handle = ent_handle;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = AW'(r_id);
                            mem_wr_data = {1'b0, ent_handle};
                        end
                    end
                end
            end
            S_SCAN: begin
                if (ent_used && !scan_last) begin
                    // keep probing: read the next candidate now
                    mem_rd_addr = cand_adv;
                    n_cand      = cand_adv;
                    n_tries     = r_tries + AW'(1);
                end else begin
                    mem_rd_addr = r_cand;
                    if (out_free) begin
                        rsp_load = 1'b1;
                        n_state  = S_IDLE;
                        if (!ent_used) begin
                            mem_wr_en     = 1'b1;
                            mem_wr_addr   = r_cand;
                            mem_wr_data   = {1'b1, r_handle};
                            n_cursor      = cand_adv;
                            rsp.status    = ST_OK;
                            rsp.result_id = ID_W'(r_cand);
                        end else begin
                            rsp.status = ST_FULL;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (rsp_load) begin
            n_out_valid = 1'b1;
            n_out       = rsp;
        end else if (!i_rsp_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_cursor    <= AW'(1);
            r_tries     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cursor    <= n_cursor;
            r_tries     <= n_tries;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand   <= n_cand;
        r_act    <= n_act;
        r_id     <= n_id;
        r_handle <= n_handle;
        r_bad    <= n_bad;
        r_out    <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // cursor always names a usable ID
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor != '0) && ({1'b0, r_cursor} < (AW+1)'(ID_COUNT)))
        else $error("allocation cursor out of range");

    // table is written only by the clearing sweep or a finishing request
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> (r_state == S_CLR) || rsp_load)
        else $error("table write outside clear or completion");

    // a response is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_rsp_stall) |-> !rsp_load)
        else $error("response overwritten while stalled");

    // an accepted request is always followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> o_req_stall)
        else $error("request accepted without going busy");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    import cia_pkg::*;

    localparam int ID_COUNT    = 1024;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int MIXED_ITEMS = 220;

    // The package has no name for the undefined action code.
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_req_valid = 1'b0;
    t_cia_req i_req       = '0;
    logic     i_rsp_stall = 1'b0;
    logic     o_req_stall;
    logic     o_rsp_valid;
    t_cia_rsp o_rsp;

    cyclic_id_allocator_unit #(
        .ID_COUNT (ID_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow ID table, kept in step with every accepted request.
    // ------------------------------------------------------------------
    bit          id_in_use   [ID_COUNT];
    logic [31:0] id_handle   [ID_COUNT];
    int unsigned alloc_cursor = 1;
    int unsigned ids_in_use   = 0;

    // Responses still owed by the block, oldest first.
    t_cia_rsp    id_responses_due[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Sender burst bookkeeping.
    int unsigned burst_left = 0;

    // Directed requests; typed-in responses are used where the row says so.
    typedef struct {
        t_cia_req req;
        bit       typed;
        t_cia_rsp rsp;
    } t_plan_row;

    t_plan_row directed_plan[$];

    function automatic int unsigned next_id(int unsigned v);
        // wraps from the top of the table back to 1, skipping ID 0
        return (v + 1 >= ID_COUNT) ? 1 : v + 1;
    endfunction

    // Response the block owes for one request; updates the shadow table.
    function automatic t_cia_rsp serve_id_request(t_cia_req r);
        t_cia_rsp    rsp;
        int unsigned cand;
        int unsigned probe_id;
        bit          id_ok;

        rsp          = '0;
        rsp.status   = ST_NOT_FOUND;
        probe_id     = 32'(r.id);
        id_ok        = (probe_id != 0) && (probe_id < ID_COUNT);
        case (r.action)
            ACT_ALLOC: begin
                cand = alloc_cursor;
                if (cand == 0 || cand >= ID_COUNT) begin
                    cand = 1;
                end
                rsp.status = ST_FULL;
                // one lap over the usable IDs at most
                for (int tries = 0; tries < ID_COUNT - 1; tries++) begin
                    if (!id_in_use[cand]) begin
                        id_in_use[cand] = 1'b1;
                        id_handle[cand] = r.handle;
                        ids_in_use++;
                        alloc_cursor    = next_id(cand);
                        rsp.status      = ST_OK;
                        rsp.result_id   = cand[ID_W-1:0];
                        break;
                    end
                    cand = next_id(cand);
                end
            end
            ACT_FIND: begin
                if (id_ok && id_in_use[probe_id]) begin
                    rsp.status        = ST_OK;
                    rsp.result_handle = id_handle[probe_id];
                end
            end
            ACT_REMOVE: begin
                if (id_ok && id_in_use[probe_id]) begin
                    id_in_use[probe_id] = 1'b0;
                    ids_in_use--;
                    rsp.status          = ST_OK;
                end
            end
            default: begin
                // undefined action: nothing changes, not-found status
            end
        endcase
        return rsp;
    endfunction

    // First used ID at or after a random start; an unused ID if the table is empty.
    function automatic int unsigned pick_used_id();
        int unsigned start;
        int unsigned cand;

        start = $urandom_range(1, ID_COUNT - 1);
        cand  = start;
        for (int k = 0; k < ID_COUNT - 1; k++) begin
            if (id_in_use[cand]) begin
                return cand;
            end
            cand = next_id(cand);
        end
        return start;
    endfunction

    // Mostly well-formed traffic; the rest is noise: random IDs, ID 0, undefined action.
    function automatic t_cia_req random_request(int alloc_pct, int find_pct, int remove_pct);
        t_cia_req    r;
        int unsigned roll;

        r.handle = $urandom;
        r.id     = ID_W'($urandom);
        roll     = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            r.action = ACT_ALLOC;
        end else if (roll < alloc_pct + find_pct) begin
            r.action = ACT_FIND;
            r.id     = ID_W'(pick_used_id());
        end else if (roll < alloc_pct + find_pct + remove_pct) begin
            r.action = ACT_REMOVE;
            r.id     = ID_W'(pick_used_id());
        end else begin
            case ($urandom_range(0, 3))
                0: r.action = ACT_FIND;
                1: r.action = ACT_REMOVE;
                2: r.action = ACT_UNDEFINED;
                default: begin
                    r.action = ($urandom_range(0, 1) != 0) ? ACT_FIND : ACT_REMOVE;
                    r.id     = '0;
                end
            endcase
        end
        return r;
    endfunction

    task automatic add_plan_row(logic [1:0] act, int unsigned id, logic [31:0] handle,
                                bit typed, logic [1:0] st, int unsigned rid,
                                logic [31:0] rhandle);
        t_plan_row row;

        row.req.action        = act;
        row.req.id            = id[ID_W-1:0];
        row.req.handle        = handle;
        row.typed             = typed;
        row.rsp.status        = st;
        row.rsp.result_id     = rid[ID_W-1:0];
        row.rsp.result_handle = rhandle;
        directed_plan.push_back(row);
    endtask

    // Drive one request in the sender's burst pattern and wait for its accept.
    task automatic issue_request(t_cia_req r, bit typed, t_cia_rsp typed_rsp);
        t_cia_rsp predicted;
        int unsigned gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            // about a quarter of bursts follow straight on
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;

        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);

        // accepted at this edge: shadow table moves on in request order
        predicted = serve_id_request(r);
        id_responses_due.push_back(typed ? typed_rsp : predicted);
    endtask

    // ------------------------------------------------------------------
    // Response side stall: modes of random length; no-stall, light, heavy,
    // and a fixed periodic pattern keyed to the cycle counter.
    // ------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: i_rsp_stall <= 1'b0;
            1: i_rsp_stall <= ($urandom_range(0, 99) < 30);
            2: i_rsp_stall <= ($urandom_range(0, 99) < 75);
            default: i_rsp_stall <= ((cycle_count % 3) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Response checker: each accepted response against the oldest one due.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, t_cia_rsp want, t_cia_rsp got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display({"%s at cycle %0d: expected status=%0d id=%0d handle=%h,",
                      " got status=%0d id=%0d handle=%h"},
                     what, cycle_count, want.status, want.result_id, want.result_handle,
                     got.status, got.result_id, got.result_handle);
        end
    endtask

    always @(posedge i_clk) begin : check_responses
        t_cia_rsp want;

        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (id_responses_due.size() == 0) begin
                report_mismatch("response with none pending", '0, o_rsp);
            end else begin
                want = id_responses_due.pop_front();
                if (o_rsp.status !== want.status || o_rsp.result_id !== want.result_id ||
                    o_rsp.result_handle !== want.result_handle) begin
                    report_mismatch("response mismatch", want, o_rsp);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_cia_req  r;
        t_plan_row row;
        int        full_allocs;

        for (int k = 0; k < ID_COUNT; k++) begin
            id_in_use[k] = 1'b0;
            id_handle[k] = '0;
        end

        // Right after reset the cursor sits at 1 and the table is empty.
        add_plan_row(ACT_ALLOC,     0,    32'hFFFF_FFFF, 1, ST_OK,        1, 32'h0);
        add_plan_row(ACT_ALLOC,     1023, 32'h0000_0000, 1, ST_OK,        2, 32'h0);
        add_plan_row(ACT_FIND,      1,    32'h0,         1, ST_OK,        0, 32'hFFFF_FFFF);
        add_plan_row(ACT_FIND,      2,    32'hFFFF_FFFF, 1, ST_OK,        0, 32'h0);
        add_plan_row(ACT_FIND,      0,    32'h0,         1, ST_NOT_FOUND, 0, 32'h0);
        add_plan_row(ACT_FIND,      1023, 32'h0,         1, ST_NOT_FOUND, 0, 32'h0);
        add_plan_row(ACT_REMOVE,    0,    32'h0,         1, ST_NOT_FOUND, 0, 32'h0);
        add_plan_row(ACT_REMOVE,    1023, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 0, 32'h0);
        add_plan_row(ACT_REMOVE,    2,    32'h0,         1, ST_OK,        0, 32'h0);
        add_plan_row(ACT_REMOVE,    2,    32'h0,         1, ST_NOT_FOUND, 0, 32'h0);
        add_plan_row(ACT_FIND,      2,    32'h0,         1, ST_NOT_FOUND, 0, 32'h0);
        // undefined action must leave ID 1 alone
        add_plan_row(ACT_UNDEFINED, 1,    32'hFFFF_FFFF, 1, ST_NOT_FOUND, 0, 32'h0);
        add_plan_row(ACT_FIND,      1,    32'h0,         1, ST_OK,        0, 32'hFFFF_FFFF);
        add_plan_row(ACT_ALLOC,     0,    32'h5555_5555, 1, ST_OK,        3, 32'h0);
        add_plan_row(ACT_ALLOC,     512,  32'hAAAA_AAAA, 1, ST_OK,        4, 32'h0);
        add_plan_row(ACT_REMOVE,    1,    32'h0,         1, ST_OK,        0, 32'h0);
        // cursor does not step back to the freed ID 2 or 1
        add_plan_row(ACT_ALLOC,     0,    32'h1234_5678, 1, ST_OK,        5, 32'h0);
        add_plan_row(ACT_FIND,      4,    32'h0,         1, ST_OK,        0, 32'hAAAA_AAAA);
        add_plan_row(ACT_UNDEFINED, 0,    32'h0,         1, ST_NOT_FOUND, 0, 32'h0);
        add_plan_row(ACT_FIND,      3,    32'h0,         0, ST_OK,        0, 32'h0);
        add_plan_row(ACT_REMOVE,    5,    32'h0,         0, ST_OK,        0, 32'h0);
        add_plan_row(ACT_ALLOC,     0,    32'h8000_0001, 0, ST_OK,        0, 32'h0);

        // Synchronous reset, then the block clears its table behind o_req_stall.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k]) begin
            row = directed_plan[k];
            issue_request(row.req, row.typed, row.rsp);
        end

        // Fill phase: allocate-heavy until every usable ID is taken; removes
        // punch holes so the search wraps and skips used entries.
        while (ids_in_use < ID_COUNT - 1) begin
            issue_request(random_request(92, 4, 2), 1'b0, '0);
        end

        // Full table: allocates run a whole lap and fail; interleaved noise may free an ID.
        for (full_allocs = 0; full_allocs < 6; full_allocs++) begin
            r        = random_request(100, 0, 0);
            issue_request(r, 1'b0, '0);
            if (full_allocs % 2 == 1) begin
                issue_request(random_request(0, 50, 0), 1'b0, '0);
            end
        end

        // Mixed phase around a near-full table: long searches, refill, refail.
        for (int k = 0; k < MIXED_ITEMS; k++) begin
            issue_request(random_request(35, 25, 25), 1'b0, '0);
        end

        i_req_valid <= 1'b0;

        // Drain, then stay quiet to catch any stray response.
        while (id_responses_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0 && id_responses_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
